### src/baro_sensor_compensation_unit_defines.svh
// Assertion macros shared by the compensation unit RTL.
// Both forms expect clk and rst in scope.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BSCU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BSCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSCU_ASSERT_IMPL(lbl, ante, cons, msg)
`define BSCU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/bscu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bscu_pkg;

  localparam int SAMPLE_W = 24;
  localparam int VALUE_W  = 32;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 64;
  localparam int QUO_W    = 45;
  localparam int ACC_FRAC = 16;
  localparam int MUL_SPLIT = 24;
  localparam int CAL_W    = 64;
  localparam int CAL_HIGH_W = 16;

  // 516096 = 63 * 2^13; x / 63 is done as 65 * x / 4095
  localparam int SCALE_HALF    = 258048;
  localparam int DIV_PRE_SHIFT = 13;
  localparam int MUL65_SHIFT   = 6;
  localparam int DIV_BASE_BITS = 12;
  localparam logic [DIV_BASE_BITS-1:0] DIV_MAX_REM = 12'hFFF;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  localparam logic [1:0] CFG_LOW  = 2'd0;
  localparam logic [1:0] CFG_MID  = 2'd1;
  localparam logic [1:0] CFG_HIGH = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN_ABS,
    ST_FIN_RND,
    ST_FIN_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_OFS,
    DV_M65,
    DV_LOOP,
    DV_DONE
  } div_state_t;

  // Horner steps: H builds the pressure cubic, G the temperature cross terms
  typedef enum logic [2:0] {
    STEP_H1,
    STEP_H2,
    STEP_H3,
    STEP_G1,
    STEP_G2,
    STEP_G3
  } step_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [QUO_W-1:0] quo;
  } div_result_t;

endpackage

`default_nettype wire

### src/bscu_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bscu_in_if import bscu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] raw_sample;

  modport source(output valid, op, raw_sample, input ready);
  modport sink(input valid, op, raw_sample, output ready);
endinterface

`default_nettype wire

### src/bscu_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bscu_out_if import bscu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic signed [VALUE_W-1:0] compensated_value;
  logic                      saturated;

  modport source(output valid, result_kind, compensated_value, saturated, input ready);
  modport sink(input valid, result_kind, compensated_value, saturated, output ready);
endinterface

`default_nettype wire

### src/bscu_divk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "baro_sensor_compensation_unit_defines.svh"

// divide by 516096, round to nearest, ties away from zero
module bscu_divk import bscu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] dividend,
  output div_result_t              result
);

  div_state_t         dstate;
  div_state_t         dstate_next;
  logic [PROD_W-2:0]  dv;
  logic [QUO_W-1:0]   q;
  logic               neg;

  logic [PROD_W-1:0]  mag_in;
  logic [PROD_W-1:0]  ofs_sum;
  logic               dv_big;
  logic [PROD_W-2:0]  dv_hi;

  assign mag_in  = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
  assign ofs_sum = {1'b0, dv} + PROD_W'(SCALE_HALF);
  assign dv_big  = |dv[PROD_W-2:DIV_BASE_BITS];
  assign dv_hi   = dv >> DIV_BASE_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (dstate)
      DV_IDLE: begin
        if (start) begin
          neg <= dividend[PROD_W-1];
          dv  <= mag_in[PROD_W-2:0];
        end
      end
      DV_OFS: begin
        dv <= (PROD_W-1)'(ofs_sum >> DIV_PRE_SHIFT);
      end
      DV_M65: begin
        dv <= dv + (dv << MUL65_SHIFT);
        q  <= '0;
      end
      DV_LOOP: begin
        if (dv_big) begin
          q  <= q + dv_hi[QUO_W-1:0];
          dv <= dv_hi + (PROD_W-1)'(dv[DIV_BASE_BITS-1:0]);
        end else begin
          q <= q + QUO_W'(dv[DIV_BASE_BITS-1:0] == DIV_MAX_REM);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dstate_next = dstate;
    result.done = 1'b0;
    result.neg  = neg;
    result.quo  = q;
    unique case (dstate)
      DV_IDLE: if (start) dstate_next = DV_OFS;
      DV_OFS:  dstate_next = DV_M65;
      DV_M65:  dstate_next = DV_LOOP;
      DV_LOOP: if (!dv_big) dstate_next = DV_DONE;
      DV_DONE: begin
        result.done = 1'b1;
        dstate_next = DV_IDLE;
      end
      default: dstate_next = DV_IDLE;
    endcase
  end

  `BSCU_ASSERT_IMPL(a_start_when_idle, start, dstate == DV_IDLE, "divider started while busy")
  `BSCU_ASSERT_NEXT(a_done_one_cycle, dstate == DV_DONE, dstate == DV_IDLE, "done held")
  `BSCU_ASSERT_NEXT(a_loop_shrinks, dstate == DV_LOOP && dv_big, dv < $past(dv), "no progress")

endmodule

`default_nettype wire

### src/baro_sensor_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "baro_sensor_compensation_unit_defines.svh"

// Barometric sensor compensation.
// samples: one word per raw 24-bit reading, op 0 temperature, op 1 pressure.
// results: one word per sample: kind, value with RESULT_FRACTION_BITS fraction
//   bits, and a flag when the value was clamped to 32 bits.
// cfg: write enable, index and data load the 18 calibration bytes; write only
//   while no sample is in flight. Index 3 is ignored.
// One 25x24 multiplier and one divide-by-516096 unit are shared by all terms.
// Each Horner step takes two partial products, one add, a divider start,
// then the divider, whose 12-bit digit loop repeats while the value has
// bits above the low 12.
// A temperature word is one step, a pressure word six, plus acceptance,
// rounding and saturation. samples.ready is high only between words. A
// finished word sits in the output register; while results is stalled the
// next sample is still accepted and computed, and its result waits until
// the register frees. Reset clears calibration, the stored temperature (a
// pressure word before any temperature uses zero) and the output valid.
module baro_sensor_compensation_unit import bscu_pkg::*; #(
  parameter int RESULT_FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CAL_W-1:0]  cfg_data,
  bscu_in_if.sink           samples,
  bscu_out_if.source        results
);

  localparam int FIN_SHIFT = ACC_FRAC - RESULT_FRACTION_BITS;
  localparam logic [ACC_W:0] RND_HALF = (ACC_W+1)'((1 << FIN_SHIFT) >> 1);
  localparam logic [ACC_W-1:0] MAG_POS_LIMIT = ACC_W'(VALUE_MAX);
  localparam logic [ACC_W-1:0] MAG_NEG_LIMIT = ACC_W'(VALUE_MIN);

  seq_state_t state;
  seq_state_t state_next;

  logic [CAL_W-1:0]      calib_low;
  logic [CAL_W-1:0]      calib_mid;
  logic [CAL_HIGH_W-1:0] calib_high;
  logic signed [SAMPLE_W-1:0] t_reg;

  logic                         op_q;
  logic signed [SAMPLE_W-1:0]   raw_q;
  step_t                        step;
  logic signed [ACC_W-1:0]      a_reg;
  logic signed [ACC_W-1:0]      h_reg;
  logic signed [MUL_SPLIT+SAMPLE_W:0] pp;
  logic signed [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]             mag;
  logic                         neg_q;

  logic                      o_valid;
  logic                      o_kind;
  logic [VALUE_W-1:0]        o_value;
  logic                      o_sat;

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    step_res;
  logic signed [MUL_SPLIT:0]  mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic                       last_step;
  logic                       out_free;
  logic                       div_start;
  div_result_t                div_res;
  logic [ACC_W:0]             rnd_sum;
  logic                       sat_now;
  logic [VALUE_W-1:0]         value_now;

  assign c0  = calib_low[63:52];
  assign c1  = calib_low[51:40];
  assign c00 = calib_low[39:20];
  assign c10 = calib_low[19:0];
  assign c01 = calib_mid[63:48];
  assign c11 = calib_mid[47:32];
  assign c20 = calib_mid[31:16];
  assign c21 = calib_mid[15:0];
  assign c30 = calib_high;

  always_comb begin
    if (op_q == OP_TEMP) begin
      addend = ACC_W'(c0) <<< (ACC_FRAC - 1);
    end else begin
      unique case (step)
        STEP_H1: addend = ACC_W'(c20) <<< ACC_FRAC;
        STEP_H2: addend = ACC_W'(c10) <<< ACC_FRAC;
        STEP_H3: addend = ACC_W'(c00) <<< ACC_FRAC;
        STEP_G1: addend = ACC_W'(c11) <<< ACC_FRAC;
        STEP_G2: addend = ACC_W'(c01) <<< ACC_FRAC;
        default: addend = h_reg;
      endcase
    end
  end

  assign step_res  = div_res.neg ? addend - $signed(ACC_W'(div_res.quo))
                                 : addend + $signed(ACC_W'(div_res.quo));
  assign last_step = (op_q == OP_TEMP) || (step == STEP_G3);
  assign mul_a     = (state == ST_MUL_LO) ? $signed({1'b0, a_reg[MUL_SPLIT-1:0]})
                                          : $signed({a_reg[ACC_W-1], a_reg[ACC_W-1:MUL_SPLIT]});
  assign mul_b     = (op_q == OP_PRES && step == STEP_G3) ? t_reg : raw_q;
  assign out_free  = !o_valid || results.ready;
  assign rnd_sum   = {1'b0, mag} + RND_HALF;

  always_comb begin
    if (neg_q) begin
      sat_now   = mag > MAG_NEG_LIMIT;
      value_now = sat_now ? VALUE_MIN : VALUE_W'(-mag[VALUE_W-1:0]);
    end else begin
      sat_now   = mag > MAG_POS_LIMIT;
      value_now = sat_now ? VALUE_MAX : mag[VALUE_W-1:0];
    end
  end

  bscu_divk u_divk (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      calib_low  <= '0;
      calib_mid  <= '0;
      calib_high <= '0;
      t_reg      <= '0;
      o_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOW:  calib_low  <= cfg_data;
          CFG_MID:  calib_mid  <= cfg_data;
          CFG_HIGH: calib_high <= cfg_data[CAL_HIGH_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_IDLE && samples.valid && samples.op == OP_TEMP) begin
        t_reg <= samples.raw_sample;
      end
      if (state == ST_FIN_OUT && out_free) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          op_q  <= samples.op;
          raw_q <= samples.raw_sample;
          step  <= STEP_H1;
          a_reg <= (samples.op == OP_TEMP) ? ACC_W'(c1) <<< ACC_FRAC
                                           : ACC_W'(c30) <<< ACC_FRAC;
        end
      end
      ST_MUL_LO: begin
        pp <= mul_a * mul_b;
      end
      ST_MUL_HI: begin
        prod <= PROD_W'(pp);
        pp   <= mul_a * mul_b;
      end
      ST_MUL_ADD: begin
        prod <= prod + (PROD_W'(pp) <<< MUL_SPLIT);
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          if (last_step) begin
            a_reg <= step_res;
          end else if (step == STEP_H3) begin
            h_reg <= step_res;
            a_reg <= ACC_W'(c21) <<< ACC_FRAC;
            step  <= step_t'(step + 3'd1);
          end else begin
            a_reg <= step_res;
            step  <= step_t'(step + 3'd1);
          end
        end
      end
      ST_FIN_ABS: begin
        neg_q <= a_reg[ACC_W-1];
        mag   <= a_reg[ACC_W-1] ? ACC_W'(-a_reg) : ACC_W'(a_reg);
      end
      ST_FIN_RND: begin
        mag <= ACC_W'(rnd_sum >> FIN_SHIFT);
      end
      ST_FIN_OUT: begin
        if (out_free) begin
          o_kind  <= op_q;
          o_value <= value_now;
          o_sat   <= sat_now;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        samples.ready = !rst;
        if (samples.valid) state_next = ST_MUL_LO;
      end
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_MUL_ADD;
      ST_MUL_ADD: state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) state_next = last_step ? ST_FIN_ABS : ST_MUL_LO;
      end
      ST_FIN_ABS: state_next = ST_FIN_RND;
      ST_FIN_RND: state_next = ST_FIN_OUT;
      ST_FIN_OUT: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  assign results.valid             = o_valid;
  assign results.result_kind       = o_kind;
  assign results.compensated_value = o_value;
  assign results.saturated         = o_sat;

  `BSCU_ASSERT_NEXT(a_accept_starts, samples.valid && samples.ready, state == ST_MUL_LO, "no start")
  `BSCU_ASSERT_IMPL(a_done_in_wait, div_res.done, state == ST_DIV_WAIT, "quotient not taken")
  `BSCU_ASSERT_IMPL(a_temp_one_step, state != ST_IDLE && op_q == OP_TEMP, step == STEP_H1, "bad step")
  `BSCU_ASSERT_NEXT(a_stall_waits, state == ST_FIN_OUT && o_valid && !results.ready,
                    state == ST_FIN_OUT, "result overwrote pending word")

endmodule

`default_nettype wire
